/* hw/rtl/salc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package salc_pkg;
  localparam int unsigned MaxSetsDef   = 256;
  localparam int unsigned MaxWaysDef   = 8;
  localparam int unsigned AddrWidthDef = 32;
  localparam int unsigned CntW         = 32;

  typedef enum logic [1:0] {
    CFG_OFFSET_BITS = 2'd0,
    CFG_INDEX_BITS  = 2'd1,
    CFG_WAYS_IN_USE = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FETCH = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic clear_en;
    logic accept;
    logic resolve;
    logic out_pop;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic out_full;
  } ctl_sts_t;
endpackage
`default_nettype wire

/* hw/rtl/set_assoc_lru_cache_lookup.sv */
`timescale 1ns / 1ps
`default_nettype none
// Set-associative LRU write-back cache lookup.
// s_axis: one access item per handshake, tdata = {opcode[1:0], address}.
// m_axis: one result per access, tdata holds hit, filled_empty, writeback,
//   way and the four saturating counters (values after this access).
// Configuration: cfg_we_i/cfg_idx_i/cfg_data_i write offset_bits (0),
//   index_bits (1) and ways_in_use (2); write only while idle.
// Timing: the set memory read and the result are both registered. A new item
//   is accepted only after the previous one resolves, set by the read-modify-write
//   of the set memory (tags, valid/dirty bits, LRU order) via its single port pair.
// Reset: a clearing pass rewrites all MAX_SETS sets (lines invalid, LRU order
//   0..MAX_WAYS-1); no item is accepted until it finishes.
// Stall: the result stays in its register while m_axis_tready is low; one
//   further item is accepted only when the result register can drain.
module set_assoc_lru_cache_lookup import salc_pkg::*; #(
  parameter int unsigned MaxSets   = MaxSetsDef,
  parameter int unsigned MaxWays   = MaxWaysDef,
  parameter int unsigned AddrWidth = AddrWidthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [3:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // address[31:0], opcode[33:32], zeros
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // hit[0], filled_empty[1], writeback[2], way[5:3], access_count[37:6],
  // hit_count[69:38], miss_count[101:70], writeback_count[133:102], zeros
  output      logic [135:0] m_axis_tdata
);
  ctl_cmd_t cmd;
  ctl_sts_t sts;
  logic hit, filled, wb;
  logic [2:0] way;
  logic [CntW-1:0] ac, hc, mc, wc;

  salc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_ready_i(m_axis_tready), .sts_i(sts), .cmd_o(cmd)
  );

  salc_datapath #(.MaxSets(MaxSets), .MaxWays(MaxWays), .AddrWidth(AddrWidth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .addr_i(AddrWidth'(s_axis_tdata[31:0])), .opcode_i(s_axis_tdata[33:32]),
    .out_valid_o(m_axis_tvalid), .hit_o(hit), .filled_o(filled), .wb_o(wb),
    .way_o(way), .acc_cnt_o(ac), .hit_cnt_o(hc), .miss_cnt_o(mc), .wb_cnt_o(wc)
  );

  assign m_axis_tdata = {2'b00, wc, mc, hc, ac, way, wb, filled, hit};
endmodule
`default_nettype wire

/* hw/rtl/salc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module salc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

/* hw/rtl/salc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module salc_ctrl import salc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output      logic     in_ready_o,
  input  wire logic     out_ready_i,
  input  wire ctl_sts_t sts_i,
  output      ctl_cmd_t cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (sts_i.clear_done) state_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i) state_d = ST_LOOKUP;
      ST_LOOKUP: state_d = ST_OUT;
      ST_OUT: begin
        // the result register drains; take the next item once room is assured
        if (!sts_i.out_full || out_ready_i) begin
          state_d = in_valid_i ? ST_LOOKUP : ST_IDLE;
        end
      end
      default:   state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR:  cmd_o.clear_en = 1'b1;
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_LOOKUP: cmd_o.resolve = 1'b1;
      ST_OUT: begin
        in_ready_o   = !sts_i.out_full || out_ready_i;
        cmd_o.accept = in_valid_i && in_ready_o;
      end
      default: ;
    endcase
    cmd_o.out_pop = out_ready_i;
  end
endmodule
`default_nettype wire

/* hw/rtl/salc_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module salc_datapath import salc_pkg::*; #(
  parameter int unsigned MaxSets   = MaxSetsDef,
  parameter int unsigned MaxWays   = MaxWaysDef,
  parameter int unsigned AddrWidth = AddrWidthDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ctl_cmd_t             cmd_i,
  output      ctl_sts_t             sts_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_idx_i,
  input  wire logic [3:0]           cfg_data_i,
  input  wire logic [AddrWidth-1:0] addr_i,
  input  wire logic [1:0]           opcode_i,
  output      logic                 out_valid_o,
  output      logic                 hit_o,
  output      logic                 filled_o,
  output      logic                 wb_o,
  output      logic [2:0]           way_o,
  output      logic [CntW-1:0]      acc_cnt_o,
  output      logic [CntW-1:0]      hit_cnt_o,
  output      logic [CntW-1:0]      miss_cnt_o,
  output      logic [CntW-1:0]      wb_cnt_o
);
  localparam int unsigned SetW  = (MaxSets > 1) ? $clog2(MaxSets) : 1;
  // largest index bit count whose sets all fit in MaxSets (floor of log2)
  localparam int unsigned MibV  = $clog2(MaxSets + 1) - 1;
  localparam int unsigned WayW  = (MaxWays > 1) ? $clog2(MaxWays) : 1;
  localparam int unsigned LruW  = MaxWays * WayW;
  // per way: valid, dirty, tag
  localparam int unsigned LineW = AddrWidth + 2;
  localparam int unsigned RowW  = MaxWays * LineW;

  logic [3:0] ob_q, ib_q, nw_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_q <= 4'd5;
      ib_q <= 4'd6;
      nw_q <= 4'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OFFSET_BITS: ob_q <= cfg_data_i;
        CFG_INDEX_BITS:  ib_q <= cfg_data_i;
        CFG_WAYS_IN_USE: nw_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // address split
  logic [3:0]           ib_eff;
  logic [4:0]           nw_eff;
  logic [AddrWidth-1:0] blk, tag_c;
  logic [SetW-1:0]      set_c;
  logic [4:0]           tshift;
  always_comb begin
    ib_eff = (ib_q > 4'(MibV)) ? 4'(MibV) : ib_q;
    nw_eff = (nw_q == 4'd0) ? 5'd1 : ((5'(nw_q) > 5'(MaxWays)) ? 5'(MaxWays) : 5'(nw_q));
    blk    = addr_i >> ob_q;
    set_c  = SetW'(blk & ((AddrWidth'(1) << ib_eff) - AddrWidth'(1)));
    tshift = 5'(ob_q) + 5'(ib_eff);
    tag_c  = addr_i >> tshift;
  end

  // clearing pass
  logic [SetW:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_en && !sts_o.clear_done) begin
      clr_q <= clr_q + 1'b1;
    end
  end
  assign sts_o.clear_done = (clr_q == (SetW+1)'(MaxSets));

  // held item
  logic [SetW-1:0]      set_q;
  logic [AddrWidth-1:0] tag_q;
  logic                 wr_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      set_q <= set_c;
      tag_q <= tag_c;
      wr_q  <= (opcode_i == OP_WRITE);
    end
  end

  // memories
  logic            row_we, lru_we;
  logic [SetW-1:0] wa;
  logic [RowW-1:0] row_rd, row_wd;
  logic [LruW-1:0] lru_rd, lru_wd, lru_init;

  always_comb begin
    for (int i = 0; i < MaxWays; i++) lru_init[i*WayW +: WayW] = WayW'(i);
  end

  salc_ram #(.Width(RowW), .Depth(MaxSets)) u_row (
    .clk_i, .we_i(row_we), .waddr_i(wa), .wdata_i(row_wd),
    .raddr_i(set_c), .rdata_o(row_rd)
  );
  salc_ram #(.Width(LruW), .Depth(MaxSets)) u_lru (
    .clk_i, .we_i(lru_we), .waddr_i(wa), .wdata_i(lru_wd),
    .raddr_i(set_c), .rdata_o(lru_rd)
  );

  // resolve
  logic            hit, filled, wb;
  logic [WayW-1:0] way;
  logic [RowW-1:0] row_new;
  logic [LruW-1:0] lru_new;
  logic            found, shifting;
  always_comb begin
    hit = 1'b0; filled = 1'b0; wb = 1'b0; way = '0; found = 1'b0;
    for (int w = 0; w < MaxWays; w++) begin
      if (!found && 5'(w) < nw_eff && row_rd[w*LineW + AddrWidth + 1]
          && row_rd[w*LineW +: AddrWidth] == tag_q) begin
        found = 1'b1; hit = 1'b1; way = WayW'(w);
      end
    end
    if (!hit) begin
      for (int w = 0; w < MaxWays; w++) begin
        if (!found && 5'(w) < nw_eff && !row_rd[w*LineW + AddrWidth + 1]) begin
          found = 1'b1; filled = 1'b1; way = WayW'(w);
        end
      end
      if (!filled) begin
        for (int p = 0; p < MaxWays; p++) begin
          if (!found && 5'(lru_rd[(MaxWays-1-p)*WayW +: WayW]) < nw_eff) begin
            found = 1'b1;
            way = lru_rd[(MaxWays-1-p)*WayW +: WayW];
          end
        end
        wb = row_rd[32'(way)*LineW + AddrWidth];
      end
    end
    row_new = row_rd;
    if (hit) begin
      if (wr_q) row_new[32'(way)*LineW + AddrWidth] = 1'b1;
    end else begin
      row_new[32'(way)*LineW +: LineW] = {1'b1, wr_q, tag_q};
    end
    // move way to front
    lru_new  = lru_rd;
    shifting = 1'b1;
    for (int p = MaxWays - 1; p > 0; p--) begin
      lru_new[p*WayW +: WayW] = lru_rd[p*WayW +: WayW];
    end
    for (int p = 0; p < MaxWays; p++) begin
      if (shifting && p > 0) lru_new[p*WayW +: WayW] = lru_rd[(p-1)*WayW +: WayW];
      if (lru_rd[p*WayW +: WayW] == way) shifting = 1'b0;
    end
    lru_new[WayW-1:0] = way;
  end

  always_comb begin
    row_we = 1'b0; lru_we = 1'b0; wa = set_q; row_wd = row_new; lru_wd = lru_new;
    if (cmd_i.clear_en) begin
      row_we = !sts_o.clear_done;
      lru_we = !sts_o.clear_done;
      wa     = clr_q[SetW-1:0];
      row_wd = '0;
      lru_wd = lru_init;
    end else if (cmd_i.resolve) begin
      row_we = 1'b1;
      lru_we = 1'b1;
    end
  end

  // counters and result register
  logic [CntW-1:0] acc_q, hc_q, mc_q, wc_q;
  logic            ov_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0; hc_q <= '0; mc_q <= '0; wc_q <= '0; ov_q <= 1'b0;
    end else begin
      if (cmd_i.out_pop) ov_q <= 1'b0;
      if (cmd_i.resolve) begin
        ov_q <= 1'b1;
        if (~&acc_q) acc_q <= acc_q + 1'b1;
        if (hit && ~&hc_q) hc_q <= hc_q + 1'b1;
        if (!hit && ~&mc_q) mc_q <= mc_q + 1'b1;
        if (wb && ~&wc_q) wc_q <= wc_q + 1'b1;
      end
    end
  end
  logic            h_q, f_q, b_q;
  logic [WayW-1:0] w_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.resolve) begin
      h_q <= hit; f_q <= filled; b_q <= wb; w_q <= way;
    end
  end

  assign sts_o.out_full = ov_q;
  assign out_valid_o    = ov_q;
  assign hit_o          = h_q;
  assign filled_o       = f_q;
  assign wb_o           = b_q;
  assign way_o          = 3'(w_q);
  assign acc_cnt_o      = acc_q;
  assign hit_cnt_o      = hc_q;
  assign miss_cnt_o     = mc_q;
  assign wb_cnt_o       = wc_q;
endmodule
`default_nettype wire
